// ===== rtl/core/tlnt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnt_pkg
// Shared types and defaults for the two-level name table.
// ----------------------------------------------------------------------------
package tlnt_pkg;

	localparam int MAX_DIRS_DEF  = 8;
	localparam int MAX_FILES_DEF = 8;
	localparam int NAME_W        = 64;
	localparam int CNT_OUT_W     = 4;

	typedef enum logic [1:0] {
		REQ_MKDIR  = 2'd0,
		REQ_MKFILE = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_SEARCH = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_NODIR  = 2'd1,
		STS_NOFILE = 2'd2,
		STS_FULL   = 2'd3
	} status_t;

	// one response beat from the controller
	typedef struct packed {
		logic                 done;
		status_t              status;
		logic [CNT_OUT_W-1:0] cnt;
	} resp_t;

endpackage
`default_nettype wire

// ===== rtl/core/tlnt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlnt_ram #(
	parameter int W  = 64,
	parameter int AW = 3
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/tlnt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnt_ctrl
// Sequencer: scans directory names, then file names, one entry per cycle,
// and writes back names and file counts.
// ----------------------------------------------------------------------------
module tlnt_ctrl #(
	parameter int MAX_DIRS  = 8,
	parameter int MAX_FILES = 8,
	parameter int DIW       = 3,
	parameter int FIW       = 3
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire tlnt_pkg::req_t             req_type,
	input  wire logic [tlnt_pkg::NAME_W-1:0] dir_name,
	input  wire logic [tlnt_pkg::NAME_W-1:0] file_name,
	output logic                            busy,
	output tlnt_pkg::resp_t                 resp,
	output logic                            dram_we,
	output logic [DIW-1:0]                  dram_waddr,
	output logic [tlnt_pkg::NAME_W-1:0]     dram_wdata,
	output logic [DIW-1:0]                  dram_raddr,
	input  wire logic [tlnt_pkg::NAME_W-1:0] dram_rdata,
	output logic                            fram_we,
	output logic [DIW+FIW-1:0]              fram_waddr,
	output logic [tlnt_pkg::NAME_W-1:0]     fram_wdata,
	output logic [DIW+FIW-1:0]              fram_raddr,
	input  wire logic [tlnt_pkg::NAME_W-1:0] fram_rdata
);
	import tlnt_pkg::*;

	localparam int DCW = $clog2(MAX_DIRS + 1);
	localparam int FCW = $clog2(MAX_FILES + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_DSCAN = 4'b0010,
		S_FSCAN = 4'b0100,
		S_MOVE  = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	logic [DCW-1:0]      dir_count_q, dir_count_d;
	logic [FCW-1:0]      fcnt_q [MAX_DIRS];
	logic                fc_we;
	logic [DIW-1:0]      fc_idx;
	logic [FCW-1:0]      fc_val;
	logic [DIW-1:0]      j_q, j_d;
	logic [DIW-1:0]      d_q, d_d;
	logic [FIW-1:0]      k_q, k_d;
	req_t                op_q;
	logic [NAME_W-1:0]   dn_q, fn_q;
	resp_t               resp_q, resp_d;
	logic [FCW-1:0]      cur_n;
	logic [FCW-1:0]      n_dec;

	assign busy  = (state_q != S_IDLE);
	assign resp  = resp_q;
	assign cur_n = fcnt_q[(state_q == S_DSCAN) ? j_q : d_q];
	assign n_dec = cur_n - FCW'(1);

	always_comb begin
		state_d     = state_q;
		dir_count_d = dir_count_q;
		j_d         = j_q;
		d_d         = d_q;
		k_d         = k_q;
		resp_d      = '{done: 1'b0, status: STS_OK, cnt: '0};
		fc_we       = 1'b0;
		fc_idx      = d_q;
		fc_val      = '0;
		dram_we     = 1'b0;
		dram_waddr  = dir_count_q[DIW-1:0];
		dram_wdata  = dir_name;
		dram_raddr  = j_q + DIW'(1);
		fram_we     = 1'b0;
		fram_waddr  = {d_q, k_q};
		fram_wdata  = fram_rdata;
		fram_raddr  = {d_q, k_q + FIW'(1)};

		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_MKDIR) begin
						if (dir_count_q == DCW'(MAX_DIRS)) begin
							resp_d = '{done: 1'b1, status: STS_FULL, cnt: '0};
						end else begin
							dram_we     = 1'b1;
							fc_we       = 1'b1;
							fc_idx      = dir_count_q[DIW-1:0];
							dir_count_d = dir_count_q + DCW'(1);
							resp_d      = '{done: 1'b1, status: STS_OK, cnt: '0};
						end
					end else if (dir_count_q == '0) begin
						resp_d = '{done: 1'b1, status: STS_NODIR, cnt: '0};
					end else begin
						dram_raddr = '0;
						j_d        = '0;
						state_d    = S_DSCAN;
					end
				end
			end
			S_DSCAN: begin
				if (dram_rdata == dn_q) begin
					d_d = j_q;
					if (op_q == REQ_MKFILE) begin
						state_d = S_IDLE;
						if (cur_n == FCW'(MAX_FILES)) begin
							resp_d = '{done: 1'b1, status: STS_FULL,
								cnt: CNT_OUT_W'(cur_n)};
						end else begin
							fram_we    = 1'b1;
							fram_waddr = {j_q, cur_n[FIW-1:0]};
							fram_wdata = fn_q;
							fc_we      = 1'b1;
							fc_idx     = j_q;
							fc_val     = cur_n + FCW'(1);
							resp_d     = '{done: 1'b1, status: STS_OK,
								cnt: CNT_OUT_W'(cur_n + FCW'(1))};
						end
					end else if (cur_n == '0) begin
						state_d = S_IDLE;
						resp_d  = '{done: 1'b1, status: STS_NOFILE, cnt: '0};
					end else begin
						fram_raddr = {j_q, FIW'(0)};
						k_d        = '0;
						state_d    = S_FSCAN;
					end
				end else if (DCW'(j_q) + DCW'(1) == dir_count_q) begin
					state_d = S_IDLE;
					resp_d  = '{done: 1'b1, status: STS_NODIR, cnt: '0};
				end else begin
					j_d = j_q + DIW'(1);
				end
			end
			S_FSCAN: begin
				if (fram_rdata == fn_q) begin
					if (op_q == REQ_SEARCH) begin
						state_d = S_IDLE;
						resp_d  = '{done: 1'b1, status: STS_OK,
							cnt: CNT_OUT_W'(cur_n)};
					end else if (FCW'(k_q) + FCW'(1) == cur_n) begin
						// hit on the last slot: just drop it
						state_d = S_IDLE;
						fc_we   = 1'b1;
						fc_val  = n_dec;
						resp_d  = '{done: 1'b1, status: STS_OK,
							cnt: CNT_OUT_W'(n_dec)};
					end else begin
						// fetch the last file to refill the hole
						fram_raddr = {d_q, n_dec[FIW-1:0]};
						state_d    = S_MOVE;
					end
				end else if (FCW'(k_q) + FCW'(1) == cur_n) begin
					state_d = S_IDLE;
					resp_d  = '{done: 1'b1, status: STS_NOFILE,
						cnt: CNT_OUT_W'(cur_n)};
				end else begin
					k_d = k_q + FIW'(1);
				end
			end
			S_MOVE: begin
				fram_we = 1'b1;
				fc_we   = 1'b1;
				fc_val  = n_dec;
				state_d = S_IDLE;
				resp_d  = '{done: 1'b1, status: STS_OK, cnt: CNT_OUT_W'(n_dec)};
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dir_count_q <= '0;
			resp_q      <= '{done: 1'b0, status: STS_OK, cnt: '0};
			for (int i = 0; i < MAX_DIRS; i++) begin
				fcnt_q[i] <= '0;
			end
		end else begin
			state_q     <= state_d;
			dir_count_q <= dir_count_d;
			resp_q      <= resp_d;
			if (fc_we) begin
				fcnt_q[fc_idx] <= fc_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		j_q <= j_d;
		d_q <= d_d;
		k_q <= k_d;
		if (start && !busy) begin
			op_q <= req_type;
			dn_q <= dir_name;
			fn_q <= file_name;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/two_level_name_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_name_table
// Directory / file name table with create, delete and search requests.
// ----------------------------------------------------------------------------
// Usage:
//  - A request (req_type, dir_name, file_name) is taken on a rising edge with
//    start high and busy low. Names are 64-bit words compared whole.
//  - Every request yields one result: done pulses for one cycle with status
//    and files_in_dir. The receiver cannot stall; the result is gone after
//    that cycle, while the block may already take the next request.
//  - Create directory, and any request that fails on an empty directory
//    table, report in the cycle after acceptance with busy staying low.
//    Other requests scan the directory name RAM one entry per cycle, then a
//    search or delete scans the file name RAM of that directory one slot per
//    cycle; a delete that must refill its hole then moves the last file in.
//    The scan speed is set by the single read port of each name RAM, one
//    compare per cycle.
//  - Reset clears the directory count and the per-directory file counts; the
//    name RAMs are not cleared, only entries below the counts are ever read.
// ----------------------------------------------------------------------------
module two_level_name_table #(
	parameter int MAX_DIRS  = tlnt_pkg::MAX_DIRS_DEF,
	parameter int MAX_FILES = tlnt_pkg::MAX_FILES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire tlnt_pkg::req_t                req_type,
	input  wire logic [tlnt_pkg::NAME_W-1:0]    dir_name,
	input  wire logic [tlnt_pkg::NAME_W-1:0]    file_name,
	output logic                               done,
	output tlnt_pkg::status_t                  status,
	output logic [tlnt_pkg::CNT_OUT_W-1:0]      files_in_dir
);
	import tlnt_pkg::*;

	// index widths, kept at one bit for single-entry tables
	localparam int DIW = (MAX_DIRS  > 1) ? $clog2(MAX_DIRS)  : 1;
	localparam int FIW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

	resp_t                resp;
	logic                 dram_we;
	logic [DIW-1:0]       dram_waddr, dram_raddr;
	logic [NAME_W-1:0]    dram_wdata, dram_rdata;
	logic                 fram_we;
	logic [DIW+FIW-1:0]   fram_waddr, fram_raddr;
	logic [NAME_W-1:0]    fram_wdata, fram_rdata;
	logic                 req_acc;

	assign req_acc      = start && !busy;
	assign done         = resp.done;
	assign status       = resp.status;
	assign files_in_dir = resp.cnt;

	// directory names, one entry per directory
	tlnt_ram #(.W(NAME_W), .AW(DIW)) u_dir_ram (
		.clk   (clk),
		.we    (dram_we),
		.waddr (dram_waddr),
		.wdata (dram_wdata),
		.raddr (dram_raddr),
		.rdata (dram_rdata)
	);

	// file names, addressed {directory, slot}
	tlnt_ram #(.W(NAME_W), .AW(DIW + FIW)) u_file_ram (
		.clk   (clk),
		.we    (fram_we),
		.waddr (fram_waddr),
		.wdata (fram_wdata),
		.raddr (fram_raddr),
		.rdata (fram_rdata)
	);

	tlnt_ctrl #(
		.MAX_DIRS  (MAX_DIRS),
		.MAX_FILES (MAX_FILES),
		.DIW       (DIW),
		.FIW       (FIW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.dir_name   (dir_name),
		.file_name  (file_name),
		.busy       (busy),
		.resp       (resp),
		.dram_we    (dram_we),
		.dram_waddr (dram_waddr),
		.dram_wdata (dram_wdata),
		.dram_raddr (dram_raddr),
		.dram_rdata (dram_rdata),
		.fram_we    (fram_we),
		.fram_waddr (fram_waddr),
		.fram_wdata (fram_wdata),
		.fram_raddr (fram_raddr),
		.fram_rdata (fram_rdata)
	);

	// a result only comes out when the sequencer has returned to idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while busy");

	// create directory reports in the cycle after it is taken, with busy low
	a_mkdir_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_type == REQ_MKDIR |=> done && !busy)
		else $error("create directory did not complete in one cycle");

	// a missing directory reports a zero count
	a_nodir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STS_NODIR |-> files_in_dir == '0)
		else $error("directory not found with nonzero count");

	// an accepted request either reports at once or starts a scan
	a_req_progress: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> done || busy)
		else $error("request dropped");

endmodule
`default_nettype wire

// ===== dv/two_level_name_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_name_table_checker
// Watches the request and result channels of the name table. It keeps its own
// copy of the directory and file tables, works out the reply for every
// accepted request, and compares each done pulse against the oldest reply owed.
// ----------------------------------------------------------------------------
module two_level_name_table_checker #(
	parameter int MAX_DIRS  = tlnt_pkg::MAX_DIRS_DEF,
	parameter int MAX_FILES = tlnt_pkg::MAX_FILES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  tlnt_pkg::req_t                 req_type,
	input  logic [tlnt_pkg::NAME_W-1:0]    dir_name,
	input  logic [tlnt_pkg::NAME_W-1:0]    file_name,
	input  logic                           done,
	input  tlnt_pkg::status_t              status,
	input  logic [tlnt_pkg::CNT_OUT_W-1:0] files_in_dir,
	output int                             mismatches,
	output int                             outstanding
);
	import tlnt_pkg::*;

	typedef struct packed {
		status_t              status;
		logic [CNT_OUT_W-1:0] count;
	} reply_t;

	// shadow tables
	int unsigned       dir_total;
	logic [NAME_W-1:0] dir_nm   [MAX_DIRS];
	int unsigned       file_cnt [MAX_DIRS];
	logic [NAME_W-1:0] file_nm  [MAX_DIRS][MAX_FILES];

	reply_t owed_replies[$];
	reply_t oldest;
	reply_t fresh;
	int     replies_seen;

	task automatic report_mismatch(input string what);
		// log only the first hundred, keep counting past that
		if (mismatches < 100)
			$display("%0t ns: reply %0d: %s", $time, replies_seen, what);
		mismatches++;
	endtask

	// Apply one request to the shadow tables and return its reply.
	task automatic predict_table_op(input req_t op, input logic [NAME_W-1:0] dn,
			input logic [NAME_W-1:0] fn, output reply_t rep);
		int          d;
		int          k;
		int unsigned n;
		d = -1;
		k = -1;
		n = 0;
		rep.status = STS_OK;
		if (op == REQ_MKDIR) begin
			if (dir_total >= MAX_DIRS) begin
				rep.status = STS_FULL;
			end else begin
				dir_nm[dir_total]   = dn;
				file_cnt[dir_total] = 0;
				dir_total++;
			end
		end else begin
			for (int i = 0; i < dir_total; i++)
				if (d < 0 && dir_nm[i] == dn)
					d = i;
			if (d < 0) begin
				rep.status = STS_NODIR;
			end else begin
				n = file_cnt[d];
				if (op == REQ_MKFILE) begin
					if (n >= MAX_FILES) begin
						rep.status = STS_FULL;
					end else begin
						file_nm[d][n] = fn;
						n++;
						file_cnt[d] = n;
					end
				end else begin
					for (int j = 0; j < n; j++)
						if (k < 0 && file_nm[d][j] == fn)
							k = j;
					if (k < 0) begin
						rep.status = STS_NOFILE;
					end else if (op == REQ_DELETE) begin
						// last file fills the hole
						file_nm[d][k] = file_nm[d][n-1];
						n--;
						file_cnt[d] = n;
					end
				end
			end
		end
		rep.count = n[CNT_OUT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_total = 0;
			foreach (file_cnt[i])
				file_cnt[i] = 0;
			owed_replies.delete();
			replies_seen = 0;
			outstanding  = 0;
			mismatches   = 0;
		end else begin
			// result first: a request accepted on this edge cannot answer on it
			if (done === 1'b1) begin
				if (owed_replies.size() == 0) begin
					report_mismatch("done pulse with no request outstanding");
				end else begin
					oldest = owed_replies.pop_front();
					if (status !== oldest.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, oldest.status));
					if (files_in_dir !== oldest.count)
						report_mismatch($sformatf("files_in_dir got %0d want %0d",
							files_in_dir, oldest.count));
				end
				replies_seen++;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_table_op(req_type, dir_name, file_name, fresh);
				owed_replies.push_back(fresh);
			end
			outstanding = owed_replies.size();
		end
	end

endmodule

// ===== dv/two_level_name_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_name_table_tb
// Drives create / delete / search requests into the name table, in bursts
// with random gaps, and leaves prediction and comparison to the checker.
// A directed run walks the corner cases (empty table, missing names, full
// tables, duplicate names, delete with refill), then random requests drawn
// from small name pools keep the tables busy near full and empty.
// ----------------------------------------------------------------------------
module two_level_name_table_tb;
	import tlnt_pkg::*;

	localparam int N_RANDOM     = 1425;
	localparam int IDLE_LIMIT   = 1000;  // cycles without any handshake
	localparam int DRAIN_CYCLES = 40;    // more than the worst-case latency
	localparam int DIR_POOL     = 10;
	localparam int FILE_POOL    = 12;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	req_t                 req_type = REQ_MKDIR;
	logic [NAME_W-1:0]    dir_name  = '0;
	logic [NAME_W-1:0]    file_name = '0;
	logic                 busy;
	logic                 done;
	status_t              status;
	logic [CNT_OUT_W-1:0] files_in_dir;

	int mismatches;
	int outstanding;
	int idle_cycles;
	int burst_left;

	// Name pools. Directories 0..6 get created (1 twice), 7..9 never exist,
	// so lookups both hit and miss.
	logic [NAME_W-1:0] dir_pool  [DIR_POOL];
	logic [NAME_W-1:0] file_pool [FILE_POOL];

	always #2 clk = ~clk;

	two_level_name_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.dir_name     (dir_name),
		.file_name    (file_name),
		.done         (done),
		.status       (status),
		.files_in_dir (files_in_dir)
	);

	two_level_name_table_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.dir_name     (dir_name),
		.file_name    (file_name),
		.done         (done),
		.status       (status),
		.files_in_dir (files_in_dir),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Watchdog: any request or result accepted restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [NAME_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// mostly pool names so lookups hit; now and then a fresh random word
	function automatic logic [NAME_W-1:0] pick_dir();
		if ($urandom_range(0, 99) < 85)
			return dir_pool[$urandom_range(0, DIR_POOL-1)];
		return rand_word();
	endfunction

	function automatic logic [NAME_W-1:0] pick_file();
		if ($urandom_range(0, 99) < 85)
			return file_pool[$urandom_range(0, FILE_POOL-1)];
		return rand_word();
	endfunction

	// Present one request and hold it until taken. start stays high across a
	// burst, so back-to-back requests touch start only once per edge. At the
	// end of a burst, start may drop for a random gap.
	task automatic send_request(input req_t op, input logic [NAME_W-1:0] dn,
			input logic [NAME_W-1:0] fn);
		int gap;
		start     <= 1'b1;
		req_type  <= op;
		dir_name  <= dn;
		file_name <= fn;
		do @(posedge clk); while (busy !== 1'b0);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		int   roll;
		req_t op;
		dir_pool[0]  = '0;
		dir_pool[1]  = '1;
		file_pool[0] = '0;
		file_pool[1] = '1;
		file_pool[2] = 64'h0000_0061_2E74_7874;  // "a.txt"
		for (int i = 2; i < DIR_POOL; i++)
			dir_pool[i] = rand_word();
		for (int i = 3; i < FILE_POOL; i++)
			file_pool[i] = rand_word();
		burst_left = $urandom_range(0, 40);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// lookup on an empty directory table
		send_request(REQ_SEARCH, dir_pool[0], file_pool[1]);
		// one directory (all-zero name), a single file, then hit / miss / delete
		send_request(REQ_MKDIR,  dir_pool[0], rand_word());
		send_request(REQ_MKFILE, dir_pool[0], file_pool[1]);
		send_request(REQ_SEARCH, dir_pool[0], file_pool[1]);
		send_request(REQ_SEARCH, dir_pool[0], file_pool[0]);
		send_request(REQ_DELETE, dir_pool[0], file_pool[0]);
		send_request(REQ_DELETE, dir_pool[0], file_pool[1]);
		// all-ones directory, created twice: lookups take the first
		send_request(REQ_MKDIR,  dir_pool[1], rand_word());
		send_request(REQ_MKDIR,  dir_pool[1], rand_word());
		// fill it, with a duplicate file name in slot 2
		for (int i = 0; i < MAX_FILES_DEF; i++)
			send_request(REQ_MKFILE, dir_pool[1], file_pool[(i == 2) ? 2 : i + 2]);
		send_request(REQ_MKFILE, dir_pool[1], file_pool[FILE_POOL-1]);  // file table full
		// delete slot 0: the last file moves in; the duplicate is still found
		send_request(REQ_DELETE, dir_pool[1], file_pool[2]);
		send_request(REQ_SEARCH, dir_pool[1], file_pool[2]);
		// fill the directory table, then one more
		for (int i = 2; i <= MAX_DIRS_DEF - 2; i++)
			send_request(REQ_MKDIR, dir_pool[i], rand_word());
		send_request(REQ_MKDIR, dir_pool[MAX_DIRS_DEF-1], rand_word());

		// --- random ---
		for (int n = 0; n < N_RANDOM; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				op = REQ_MKDIR;
			else if (roll < 45)
				op = REQ_MKFILE;
			else if (roll < 75)
				op = REQ_DELETE;
			else
				op = REQ_SEARCH;
			send_request(op, pick_dir(), (op == REQ_MKDIR) ? rand_word() : pick_file());
		end

		// drain: every reply in, then a margin for strays
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
